// ----- hdl/pfr_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfr_pkg
// Shared types and constants for the framed packet receiver.
// ---------------------------------------------------------------------------
package pfr_pkg;

    // Register map (word index, byte address is 4 * index)
    localparam logic [0:0] REG_START_BYTE   = 1'b0;
    localparam logic [7:0] START_BYTE_RESET = 8'h7E;

    // Receive phase
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_TYPE   = 3'd1,
        PH_LENGTH = 3'd2,
        PH_DATA   = 3'd3,
        PH_CHECK  = 3'd4
    } t_phase;

    // Role tag given to each received byte
    typedef enum logic [2:0] {
        ROLE_IGNORED = 3'd0,
        ROLE_START   = 3'd1,
        ROLE_TYPE    = 3'd2,
        ROLE_LENGTH  = 3'd3,
        ROLE_DATA    = 3'd4,
        ROLE_CHECK   = 3'd5
    } t_role;

    // One result per received byte
    typedef struct packed {
        t_role      role;
        logic [7:0] value;
        logic [5:0] data_index;
        logic       frame_end;
        logic       checksum_bad;
        logic [7:0] frame_type;
        logic [7:0] frame_length;
    } t_result;

endpackage

// ----- hdl/packet_frame_receiver.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// packet_frame_receiver
// Start-byte framed packet receiver with XOR checksum check.
// ---------------------------------------------------------------------------
// Each received byte gives exactly one result tagging it as ignored, start,
// type, length, data or checksum. The block takes one byte per clock cycle
// while the output does not stall. The input register takes a byte when its
// request is accepted, and the result register takes its result when the
// byte moves on from the input register, so the output comes from a register;
// the frame state machine updates once per byte taken, which sets this rate.
// Stalls on the output side back up through the result register to
// s_axis_tready. While idle, bytes are dropped until one equals the
// start_byte register (address 0, reset 0x7E); then type, length,
// min(length, MAX_DATA) data bytes and a checksum byte follow. The checksum
// is the XOR of type, length and the data taken.
// ---------------------------------------------------------------------------
module packet_frame_receiver
    import pfr_pkg::*;
#(
    parameter int MAX_DATA = 64        // 1 .. 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] value, [13:8] data_index,
                                        // [14] checksum_bad, [22:15] frame_type,
                                        // [30:23] frame_length, [31] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] role
    output logic        m_axis_tlast,   // frame_end
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] r_start_byte;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    logic       w_adv;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_START_BYTE) ? {24'd0, r_start_byte} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == REG_START_BYTE)) begin
            r_start_byte <= pwdata[7:0];
        end
    end

    // Byte moves from the input register into the result register
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    pfr_parser #(
        .MAX_DATA (MAX_DATA)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_adv),
        .i_byte       (r_in_byte),
        .i_start_byte (r_start_byte),
        .o_result     (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.role;
    assign m_axis_tlast  = r_out.frame_end;
    assign m_axis_tdata  = {1'b0, r_out.frame_length, r_out.frame_type,
                            r_out.checksum_bad, r_out.data_index, r_out.value};

`ifndef ASSERT_OFF
    // An empty input register always takes a new request
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input register empty but not ready");

    // A byte that leaves the input register lands in the result register
    a_adv_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("advanced byte lost before the result register");

    // A checksum error is only flagged on the checksum byte
    a_bad_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.checksum_bad) |-> (r_out.frame_end &&
                                                 r_out.role == ROLE_CHECK))
        else $error("checksum error outside a checksum byte");
`endif

endmodule

// ----- hdl/pfr_parser.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfr_parser
// Frame state machine: tags each byte, keeps type, length, byte count and
// the running XOR, and checks the checksum byte.
// ---------------------------------------------------------------------------
module pfr_parser
    import pfr_pkg::*;
#(
    parameter int MAX_DATA = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,        // take i_byte this cycle
    input  logic [7:0] i_byte,
    input  logic [7:0] i_start_byte,
    output t_result    o_result       // result for i_byte, valid with i_step
);

    localparam int CW = $clog2(MAX_DATA + 1);

    t_phase          r_phase, n_phase;
    logic [7:0]      r_type,  n_type;
    logic [7:0]      r_len,   n_len;
    logic [CW-1:0]   r_cnt,   n_cnt;
    logic [7:0]      r_xor,   n_xor;
    logic [CW-1:0]   w_cnt_inc;
    logic            w_data_done;

    // Count never exceeds MAX_DATA, so the increment cannot wrap in the data phase
    assign w_cnt_inc   = r_cnt + CW'(1);
    assign w_data_done = (9'(w_cnt_inc) >= {1'b0, r_len}) ||
                         (w_cnt_inc >= CW'(MAX_DATA));

    // Next state and held frame fields
    always_comb begin
        n_phase = r_phase;
        n_type  = r_type;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_xor   = r_xor;
        unique case (r_phase)
            PH_TYPE: begin
                n_type  = i_byte;
                n_xor   = i_byte;
                n_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                n_len   = i_byte;
                n_xor   = r_xor ^ i_byte;
                n_cnt   = '0;
                // empty payload goes straight to the checksum
                n_phase = (i_byte == 8'd0) ? PH_CHECK : PH_DATA;
            end
            PH_DATA: begin
                n_xor = r_xor ^ i_byte;
                n_cnt = w_cnt_inc;
                if (w_data_done) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_phase = PH_IDLE;
            end
            default: begin
                if (i_byte == i_start_byte) begin
                    n_xor   = '0;
                    n_cnt   = '0;
                    n_phase = PH_TYPE;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    // Result for the byte being taken
    always_comb begin
        o_result              = '0;
        o_result.value        = i_byte;
        o_result.frame_type   = n_type;
        o_result.frame_length = n_len;
        unique case (r_phase)
            PH_TYPE:   o_result.role = ROLE_TYPE;
            PH_LENGTH: o_result.role = ROLE_LENGTH;
            PH_DATA: begin
                o_result.role       = ROLE_DATA;
                o_result.data_index = 6'(r_cnt);   // wraps beyond 63
            end
            PH_CHECK: begin
                o_result.role         = ROLE_CHECK;
                o_result.frame_end    = 1'b1;
                o_result.checksum_bad = (r_xor != i_byte);
            end
            default: begin
                o_result.role = (i_byte == i_start_byte) ? ROLE_START : ROLE_IGNORED;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_type  <= '0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_xor   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_type  <= n_type;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_xor   <= n_xor;
        end
    end

endmodule
